// ----- rtl/mm4_pkg.sv -----
// Shared constants and types of the 4x4 fixed-point matrix multiplier.
`default_nettype none
package mm4_pkg;

  localparam int DIM      = 4;
  localparam int IDX_W    = $clog2(DIM);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = DIM * DIM;
  localparam int SIZE_W   = 3;
  localparam int ELEM_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_W    = PROD_W + IDX_W;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DIM);

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic              a_en;
    logic              b_en;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/mm4_store.sv -----
// Element stores for matrices A and B with registered read ports.
`default_nettype none
module mm4_store (
  input  wire logic                       clk,
  input  wire mm4_pkg::store_wr_t         wr,
  input  wire logic                       rd_en,
  input  wire logic [mm4_pkg::ADDR_W-1:0] rd_addr_a,
  input  wire logic [mm4_pkg::ADDR_W-1:0] rd_addr_b,
  output logic      [mm4_pkg::ELEM_W-1:0] rd_a,
  output logic      [mm4_pkg::ELEM_W-1:0] rd_b
);

  logic [mm4_pkg::ELEM_W-1:0] mem_a [mm4_pkg::DEPTH];
  logic [mm4_pkg::ELEM_W-1:0] mem_b [mm4_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.a_en) begin
      mem_a[wr.addr] <= wr.data;
    end
    if (wr.b_en) begin
      mem_b[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_a <= mem_a[rd_addr_a];
      rd_b <= mem_b[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mm4_mac.sv -----
// Shared multiply-accumulate unit with Q16.16 rescale and saturation.
`default_nettype none
module mm4_mac (
  input  wire logic                       clk,
  input  wire mm4_pkg::mac_ctl_t          ctl,
  input  wire logic [mm4_pkg::ELEM_W-1:0] a,
  input  wire logic [mm4_pkg::ELEM_W-1:0] b,
  output logic      [mm4_pkg::ELEM_W-1:0] result,
  output logic                            ovf
);

  localparam int TOP_LSB = mm4_pkg::FRAC_W + mm4_pkg::ELEM_W - 1;

  logic signed [mm4_pkg::PROD_W-1:0] prod;
  logic signed [mm4_pkg::ACC_W-1:0]  acc;
  logic signed [mm4_pkg::ACC_W-1:0]  acc_base;
  logic        [mm4_pkg::ACC_W-TOP_LSB-1:0] top_bits;
  logic                              sign;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= $signed(a) * $signed(b);
    end
    if (ctl.acc_en) begin
      acc <= acc_base + mm4_pkg::ACC_W'(prod);
    end
  end

  always_comb begin
    acc_base = ctl.acc_clr ? '0 : acc;
    top_bits = acc[mm4_pkg::ACC_W-1:TOP_LSB];
    sign     = acc[mm4_pkg::ACC_W-1];
    ovf      = sign ? (top_bits != '1) : (top_bits != '0);
    if (ovf) begin
      result = sign ? mm4_pkg::ELEM_MIN : mm4_pkg::ELEM_MAX;
    end else begin
      result = acc[TOP_LSB:mm4_pkg::FRAC_W];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/matrix_multiply_4x4_top.sv -----
// Top level of the 4x4 fixed-point matrix multiplier: sequencer and ports.
//
// Input channel (in_valid / in_stall) takes one item per beat: opcode 0 or 1
// writes value into A or B at (row, col); opcode 2 starts a product of the
// leading active_size x active_size corners (active_size above 4 counts as 4;
// 0 starts nothing); opcode 3 is dropped. in_stall is high while a product is worked out.
// The product comes out on the output channel (out_valid / out_stall) in
// row-major order, one element per beat, with last on the final element
// and overflow where the element saturated to 32 bits.
// Each element is worked out on the one shared multiply-accumulate
// unit: a store read, a multiply and an accumulate per term, then the
// rescaled sum is taken into the output register.
// A finished element sits in the output register; the sequencer carries on
// with the next element and waits only while that register is full and stalled.
// The configuration channel (cfg_valid / cfg_ready) writes active_size;
// write it only while no product is in flight.
// Reset sets active_size to 4 and empties the output register; the
// element stores hold nothing defined until loaded.
`default_nettype none
module matrix_multiply_4x4_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mm4_pkg::SIZE_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mm4_pkg::OP_W-1:0]    opcode,
  input  wire logic [mm4_pkg::IDX_W-1:0]   row,
  input  wire logic [mm4_pkg::IDX_W-1:0]   col,
  input  wire logic [mm4_pkg::ELEM_W-1:0]  value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [mm4_pkg::IDX_W-1:0]   out_row,
  output logic      [mm4_pkg::IDX_W-1:0]   out_col,
  output logic      [mm4_pkg::ELEM_W-1:0]  out_value,
  output logic                             overflow,
  output logic                             last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [mm4_pkg::SIZE_W-1:0] active_size;
  logic [mm4_pkg::IDX_W-1:0]  last_idx;
  logic [mm4_pkg::IDX_W-1:0]  i, j, k;
  logic [mm4_pkg::IDX_W-1:0]  i_next, j_next, k_next;
  logic [mm4_pkg::SIZE_W-1:0] size_clip;
  logic                       in_accept;
  logic                       start;
  logic                       out_load;
  logic                       elem_last;
  logic                       k_end;

  mm4_pkg::store_wr_t         wr;
  mm4_pkg::mac_ctl_t          mac_ctl;
  logic [mm4_pkg::ELEM_W-1:0] rd_a, rd_b;
  logic [mm4_pkg::ELEM_W-1:0] mac_result;
  logic                       mac_ovf;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    size_clip = (active_size > mm4_pkg::SIZE_RESET) ? mm4_pkg::SIZE_RESET : active_size;
    start     = in_accept && (opcode == mm4_pkg::OP_COMPUTE) && (size_clip != '0);
    wr.a_en   = in_accept && (opcode == mm4_pkg::OP_LOAD_A);
    wr.b_en   = in_accept && (opcode == mm4_pkg::OP_LOAD_B);
    wr.addr   = {row, col};
    wr.data   = value;
    k_end     = (k == last_idx);
    elem_last = (i == last_idx) && (j == last_idx);
    out_load  = (state == S_DONE) && (!out_valid || !out_stall);
    mac_ctl.mul_en  = (state == S_MUL);
    mac_ctl.acc_en  = (state == S_ACC);
    mac_ctl.acc_clr = (k == '0);
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
        end
      end
      S_READ: state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC: begin
        if (k_end) begin
          state_next = S_DONE;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_load) begin
          k_next = '0;
          if (elem_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
            if (j == last_idx) begin
              j_next = '0;
              i_next = i + 1'b1;
            end else begin
              j_next = j + 1'b1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active_size <= mm4_pkg::SIZE_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_size <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    k <= k_next;
    if (start) begin
      last_idx <= mm4_pkg::IDX_W'(size_clip - 1'b1);
    end
    if (out_load) begin
      out_row   <= i;
      out_col   <= j;
      out_value <= mac_result;
      overflow  <= mac_ovf;
      last      <= elem_last;
    end
  end

  mm4_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (state == S_READ),
    .rd_addr_a ({i, k}),
    .rd_addr_b ({k, j}),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  mm4_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (rd_a),
    .b      (rd_b),
    .result (mac_result),
    .ovf    (mac_ovf)
  );

  a_start_reads: assert property (@(posedge clk) disable iff (rst)
    start |=> state == S_READ)
    else $error("compute item did not start a store read");

  a_term_count: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC && k_end |=> state == S_DONE && k == $past(k))
    else $error("element finished before its last term");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && elem_last |=> state == S_IDLE && out_valid && last)
    else $error("final element did not return the sequencer to idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && state == S_DONE |=> state == S_DONE)
    else $error("sequencer advanced over a held result");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> in_stall && $past(state) == S_READ)
    else $error("multiply step out of order");

endmodule
`default_nettype wire

// ----- sim/tb_matrix_multiply_4x4_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 4x4 fixed-point matrix multiplier top level.
module tb_matrix_multiply_4x4_top;
  import mm4_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 240;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 180;
  localparam int PRINT_LIMIT   = 200;
  localparam logic signed [71:0] SUM_HI = 72'sd2147483647;
  localparam logic signed [71:0] SUM_LO = -72'sd2147483648;
  localparam logic [ELEM_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [ELEM_W-1:0] LSB_NEG   = 32'hFFFF_FFFF;

  typedef struct {
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    logic [ELEM_W-1:0] v;
    logic              ovf;
    logic              lst;
  } elem_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SIZE_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     opcode;
  logic [IDX_W-1:0]    row;
  logic [IDX_W-1:0]    col;
  logic [ELEM_W-1:0]   value;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IDX_W-1:0]    out_row;
  logic [IDX_W-1:0]    out_col;
  logic [ELEM_W-1:0]   out_value;
  logic                overflow;
  logic                last;

  logic [ELEM_W-1:0]   a_elems [DEPTH];
  logic [ELEM_W-1:0]   b_elems [DEPTH];
  logic [SIZE_W-1:0]   size_model;
  elem_t               pending_elems [$];
  int                  errors = 0;
  int                  cycles = 0;
  int                  items_sent = 0;
  int                  stall_left = 0;
  bit                  idling_on = 1'b1;

  matrix_multiply_4x4_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .overflow  (overflow),
    .last      (last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_matrix_multiply_4x4_top failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [ELEM_W-1:0] got, logic [ELEM_W-1:0] want);
    if (errors < PRINT_LIMIT)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic elem_t product_elem(int i, int j, int n);
    logic signed [71:0] sum;
    logic signed [71:0] scaled;
    logic signed [71:0] ea;
    logic signed [71:0] eb;
    elem_t e;
    sum = '0;
    for (int k = 0; k < n; k++) begin
      ea = $signed(a_elems[i * DIM + k]);
      eb = $signed(b_elems[k * DIM + j]);
      sum = sum + ea * eb;
    end
    scaled = sum >>> FRAC_W;
    if (scaled > SUM_HI) begin
      e.v = ELEM_MAX;
      e.ovf = 1'b1;
    end else if (scaled < SUM_LO) begin
      e.v = ELEM_MIN;
      e.ovf = 1'b1;
    end else begin
      e.v = scaled[ELEM_W-1:0];
      e.ovf = 1'b0;
    end
    e.r = IDX_W'(i);
    e.c = IDX_W'(j);
    e.lst = (i == n - 1) && (j == n - 1);
    return e;
  endfunction

  task automatic predict_product();
    int n;
    n = (size_model > DIM) ? DIM : int'(size_model);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        pending_elems.push_back(product_elem(i, j, n));
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 6))
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return '0;
          3: return ELEM_W'(1);
          4: return LSB_NEG;
          5: return Q_ONE;
          default: return Q_NEG_ONE;
        endcase
      end
      1, 2: return ELEM_W'(int'($urandom_range(0, 'h60000)) - 'h30000);
      3: return ELEM_W'(int'($urandom_range(0, 'h200_0000)) - 'h100_0000);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [ELEM_W-1:0] v);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    row <= r;
    col <= c;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      OP_LOAD_A:  a_elems[{r, c}] = v;
      OP_LOAD_B:  b_elems[{r, c}] = v;
      OP_COMPUTE: predict_product();
      default: ;
    endcase
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_compute();
    send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
  endtask

  task automatic send_noise();
    send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
  endtask

  task automatic load_corner(int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        send_item(OP_LOAD_A, IDX_W'(r), IDX_W'(c), rand_elem());
        send_item(OP_LOAD_B, IDX_W'(r), IDX_W'(c), rand_elem());
      end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] s);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_model = s;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic single_product(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    send_item(OP_LOAD_A, '0, '0, a);
    send_item(OP_LOAD_B, '0, '0, b);
    send_compute();
  endtask

  // every element gets written before the first product reads it
  task automatic test_reset_size();
    load_corner(DIM);
    send_compute();
  endtask

  task automatic test_saturation();
    write_size(SIZE_W'(1));
    single_product(ELEM_MAX, ELEM_MAX);
    single_product(ELEM_MIN, ELEM_MIN);
    single_product(ELEM_MIN, ELEM_MAX);
    single_product(LSB_NEG, ELEM_W'(1));
    single_product(Q_ONE, Q_NEG_ONE);
  endtask

  task automatic test_unused_opcode();
    send_noise();
    send_item(OP_UNUSED, '1, '1, ELEM_MAX);
    send_compute();
  endtask

  task automatic test_size_codes();
    write_size(SIZE_W'(0));
    send_compute();
    write_size(SIZE_W'(7));
    send_compute();
    write_size(SIZE_W'(5));
    send_compute();
    write_size(SIZE_W'(2));
    send_compute();
    write_size(SIZE_W'(3));
    send_compute();
  endtask

  task automatic test_random_jobs();
    int start;
    int jobs;
    int n;
    int loads;
    logic [SIZE_W-1:0] s;
    start = items_sent;
    jobs = 0;
    idling_on = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      s = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(5, 8) & 7)
                                      : SIZE_W'($urandom_range(1, 4));
      write_size(s);
      n = (s > DIM) ? DIM : int'(s);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) begin
          load_corner(n);
        end else begin
          loads = $urandom_range(0, 6);
          repeat (loads)
            send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                      IDX_W'($urandom), IDX_W'($urandom), rand_elem());
        end
        if ($urandom_range(0, 4) == 0) send_noise();
        send_compute();
        if (jobs % 5 == 2) wait_drained();
        jobs++;
      end
    end
  endtask

  task automatic test_no_idle();
    idling_on = 1'b0;
    write_size(SIZE_W'(4));
    load_corner(DIM);
    send_compute();
    send_compute();
  endtask

  always @(negedge clk) begin
    if (idling_on && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    elem_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        report_mismatch("unexpected product beat", out_value, '0);
      end else begin
        want = pending_elems.pop_front();
        if (out_row !== want.r) report_mismatch("out_row", ELEM_W'(out_row), ELEM_W'(want.r));
        if (out_col !== want.c) report_mismatch("out_col", ELEM_W'(out_col), ELEM_W'(want.c));
        if (out_value !== want.v) report_mismatch("out_value", out_value, want.v);
        if (overflow !== want.ovf)
          report_mismatch("overflow", ELEM_W'(overflow), ELEM_W'(want.ovf));
        if (last !== want.lst) report_mismatch("last", ELEM_W'(last), ELEM_W'(want.lst));
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_LOAD_A;
    row = '0;
    col = '0;
    value = '0;
    size_model = SIZE_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_saturation();
    test_unused_opcode();
    test_size_codes();
    test_random_jobs();
    test_no_idle();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_matrix_multiply_4x4_top passed");
    else
      $display("tb_matrix_multiply_4x4_top failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mm4_pkg.sv
rtl/mm4_store.sv
rtl/mm4_mac.sv
rtl/matrix_multiply_4x4_top.sv
sim/tb_matrix_multiply_4x4_top.sv
